FILE: rtl/core/cmph_pkg.sv
// ----------------------------------------------------------------------------
// cmph_pkg: shared types and constants for the compass heading block
// Command codes, sequencer states, CORDIC angle units and arctangent table.
// ----------------------------------------------------------------------------
package cmph_pkg;

    // Command codes carried by an input item
    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_CAL     = 2'd1;
    localparam logic [1:0] CMD_HEADING = 2'd2;

    // Field widths
    localparam int SAMPLE_W  = 16;
    localparam int DELTA_W   = 17;
    localparam int HEADING_W = 15;

    // CORDIC datapath: 17 bit delta scaled by 2^24, plus growth headroom
    localparam int FRAC_SHIFT = 24;
    localparam int VEC_W      = 45;
    localparam int ANG_W      = 24;

    // Angle accumulator in 1/16384 degree
    localparam logic signed [ANG_W-1:0] ANG_FULL = 24'sd5898240;
    localparam logic signed [ANG_W-1:0] ANG_HALF = 24'sd2949120;
    localparam logic [ANG_W-1:0]        ANG_RND  = 24'd128;

    // Heading in 1/64 degree: 360 degrees
    localparam logic [HEADING_W-1:0] HEADING_FULL = 15'd23040;

    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IDX_W   = 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CENTER,
        S_SETUP,
        S_LAUNCH,
        S_CORDIC,
        S_DONE
    } seq_state_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROTATE,
        C_WRAP,
        C_ROUND
    } cordic_state_t;

    typedef struct packed {
        logic load;   // item accepted this cycle
        logic eval;   // refresh centers and calibrated flag
    } minmax_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cordic_stat_t;

    // atan(2^-i) in 1/16384 degree, rounded to nearest
    function automatic logic signed [ANG_W-1:0] atan_lookup(
        input logic [ATAN_IDX_W-1:0] idx
    );
        logic signed [ANG_W-1:0] val;
        case (idx)
            5'd0:    val = 24'sd737280;
            5'd1:    val = 24'sd435242;
            5'd2:    val = 24'sd229970;
            5'd3:    val = 24'sd116736;
            5'd4:    val = 24'sd58595;
            5'd5:    val = 24'sd29326;
            5'd6:    val = 24'sd14667;
            5'd7:    val = 24'sd7334;
            5'd8:    val = 24'sd3667;
            5'd9:    val = 24'sd1833;
            5'd10:   val = 24'sd917;
            5'd11:   val = 24'sd458;
            5'd12:   val = 24'sd229;
            5'd13:   val = 24'sd115;
            5'd14:   val = 24'sd57;
            5'd15:   val = 24'sd29;
            5'd16:   val = 24'sd14;
            5'd17:   val = 24'sd7;
            5'd18:   val = 24'sd4;
            5'd19:   val = 24'sd2;
            5'd20:   val = 24'sd1;
            default: val = 24'sd0;
        endcase
        return val;
    endfunction

endpackage

FILE: rtl/core/cmph_minmax.sv
// ----------------------------------------------------------------------------
// cmph_minmax: hard-iron extreme tracker
// Keeps per-axis running min/max, derives centers and the calibrated flag.
// ----------------------------------------------------------------------------
module cmph_minmax
    import cmph_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  minmax_ctl_t                ctl,
    input  logic [1:0]                 command,
    input  logic signed [SAMPLE_W-1:0] mag_x,
    input  logic signed [SAMPLE_W-1:0] mag_y,
    input  logic [SAMPLE_W-1:0]        threshold,
    output logic signed [SAMPLE_W-1:0] center_x,
    output logic signed [SAMPLE_W-1:0] center_y,
    output logic                       calibrated
);

    logic signed [SAMPLE_W-1:0] max_x_reg, max_x_next;
    logic signed [SAMPLE_W-1:0] min_x_reg, min_x_next;
    logic signed [SAMPLE_W-1:0] max_y_reg, max_y_next;
    logic signed [SAMPLE_W-1:0] min_y_reg, min_y_next;
    logic                       have_sample_reg, have_sample_next;
    logic signed [SAMPLE_W-1:0] center_x_reg, center_x_next;
    logic signed [SAMPLE_W-1:0] center_y_reg, center_y_next;
    logic                       calibrated_reg, calibrated_next;

    logic signed [DELTA_W-1:0] sum_x, sum_y;
    logic [DELTA_W-1:0]        spread_x, spread_y;

    always_comb
    begin
        max_x_next       = max_x_reg;
        min_x_next       = min_x_reg;
        max_y_next       = max_y_reg;
        min_y_next       = min_y_reg;
        have_sample_next = have_sample_reg;
        if (ctl.load)
        begin
            case (command)
                CMD_CLEAR:
                begin
                    max_x_next       = '0;
                    min_x_next       = '0;
                    max_y_next       = '0;
                    min_y_next       = '0;
                    have_sample_next = 1'b0;
                end
                CMD_CAL:
                begin
                    // seed all extremes from the first sample
                    if (!have_sample_reg)
                    begin
                        max_x_next = mag_x;
                        min_x_next = mag_x;
                        max_y_next = mag_y;
                        min_y_next = mag_y;
                    end
                    else
                    begin
                        if (mag_x > max_x_reg) max_x_next = mag_x;
                        if (mag_x < min_x_reg) min_x_next = mag_x;
                        if (mag_y > max_y_reg) max_y_next = mag_y;
                        if (mag_y < min_y_reg) min_y_next = mag_y;
                    end
                    have_sample_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // center = (max + min) >>> 1, spread = max - min (never negative)
    assign sum_x    = DELTA_W'(max_x_reg) + DELTA_W'(min_x_reg);
    assign sum_y    = DELTA_W'(max_y_reg) + DELTA_W'(min_y_reg);
    assign spread_x = DELTA_W'(max_x_reg) - DELTA_W'(min_x_reg);
    assign spread_y = DELTA_W'(max_y_reg) - DELTA_W'(min_y_reg);

    always_comb
    begin
        center_x_next   = center_x_reg;
        center_y_next   = center_y_reg;
        calibrated_next = calibrated_reg;
        if (ctl.eval)
        begin
            center_x_next   = sum_x[DELTA_W-1:1];
            center_y_next   = sum_y[DELTA_W-1:1];
            calibrated_next = (spread_x > {1'b0, threshold}) &&
                              (spread_y > {1'b0, threshold});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg       <= '0;
            min_x_reg       <= '0;
            max_y_reg       <= '0;
            min_y_reg       <= '0;
            have_sample_reg <= 1'b0;
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            calibrated_reg  <= 1'b0;
        end
        else
        begin
            max_x_reg       <= max_x_next;
            min_x_reg       <= min_x_next;
            max_y_reg       <= max_y_next;
            min_y_reg       <= min_y_next;
            have_sample_reg <= have_sample_next;
            center_x_reg    <= center_x_next;
            center_y_reg    <= center_y_next;
            calibrated_reg  <= calibrated_next;
        end
    end

    assign center_x   = center_x_reg;
    assign center_y   = center_y_reg;
    assign calibrated = calibrated_reg;

endmodule

FILE: rtl/core/cmph_cordic.sv
// ----------------------------------------------------------------------------
// cmph_cordic: iterative vectoring CORDIC
// One shift/add rotation per cycle, then wrap to [0,360) and round.
// ----------------------------------------------------------------------------
module cmph_cordic
    import cmph_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [DELTA_W-1:0]   dx,
    input  logic signed [DELTA_W-1:0]   dy,
    output cordic_stat_t                stat,
    output logic [HEADING_W-1:0]        angle
);

    localparam int NSTEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam logic [ATAN_IDX_W-1:0] LAST_STEP = ATAN_IDX_W'(NSTEPS - 1);

    cordic_state_t state_reg, state_next;
    logic [ATAN_IDX_W-1:0]    step_reg, step_next;
    logic signed [VEC_W-1:0]  x_reg, x_next;
    logic signed [VEC_W-1:0]  y_reg, y_next;
    logic signed [ANG_W-1:0]  z_reg, z_next;

    logic signed [VEC_W-1:0]  x_init, y_init, x_sh, y_sh;
    logic signed [ANG_W-1:0]  atan_val;
    logic [ANG_W-1:0]         z_rnd;
    logic [HEADING_W-1:0]     angle_raw;

    assign x_init   = VEC_W'(dy) <<< FRAC_SHIFT;
    assign y_init   = VEC_W'(dx) <<< FRAC_SHIFT;
    assign x_sh     = x_reg >>> step_reg;
    assign y_sh     = y_reg >>> step_reg;
    assign atan_val = atan_lookup(step_reg);

    assign z_rnd     = $unsigned(z_reg) + ANG_RND;
    assign angle_raw = z_rnd[HEADING_W+7:8];

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    // turn a vector pointing south by half a circle first
                    if (dy < 0)
                    begin
                        x_next = -x_init;
                        y_next = -y_init;
                        z_next = ANG_HALF;
                    end
                    else
                    begin
                        x_next = x_init;
                        y_next = y_init;
                        z_next = '0;
                    end
                    step_next  = '0;
                    state_next = C_ROTATE;
                end
            end
            C_ROTATE:
            begin
                if (y_reg > 0)
                begin
                    x_next = x_reg + y_sh;
                    y_next = y_reg - x_sh;
                    z_next = z_reg + atan_val;
                end
                else
                begin
                    x_next = x_reg - y_sh;
                    y_next = y_reg + x_sh;
                    z_next = z_reg - atan_val;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                    state_next = C_WRAP;
            end
            C_WRAP:
            begin
                if (z_reg < 0)
                    z_next = z_reg + ANG_FULL;
                else if (z_reg >= ANG_FULL)
                    z_next = z_reg - ANG_FULL;
                state_next = C_ROUND;
            end
            C_ROUND:
            begin
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    // a full circle after rounding folds back to north
    assign angle     = (angle_raw >= HEADING_FULL) ? '0 : angle_raw;
    assign stat.busy = (state_reg != C_IDLE);
    assign stat.done = (state_reg == C_ROUND);

endmodule

FILE: rtl/core/compass_hard_iron_heading.sv
// ----------------------------------------------------------------------------
// compass_hard_iron_heading: hard-iron calibrated compass heading
// Min/max calibration of magnetometer X/Y and CORDIC atan2 heading.
// ----------------------------------------------------------------------------
// Each accepted item gives exactly one result item. A clear command drops
// the stored extremes, a calibration sample widens the per-axis min/max
// (the first one after reset or clear seeds them), and a heading sample
// subtracts the hard-iron centers and reports atan2(dx,dy) in 1/64 degree,
// 0 = +Y, 90 degrees = +X. A zero vector or any non-heading command
// returns the last heading with heading_valid low. The result always
// carries the current centers and the calibrated flag (both spreads
// strictly above spread_threshold). A heading item with a nonzero vector
// holds the input from accept until its result is loaded, and runs through
// the single shift/add CORDIC unit doing one rotation per cycle. Any other
// item, a zero vector included, skips the CORDIC. A result still waiting
// in the output register adds its wait to the next item. The input stalls
// while an item is at work; the result sits in its own register, so the
// next item can be accepted while it waits.
// Write spread_threshold only while the block is idle.
// ----------------------------------------------------------------------------
module compass_hard_iron_heading
    import cmph_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // threshold register
    input  logic                        cfg_we,
    input  logic [SAMPLE_W-1:0]         cfg_wdata,
    // sample channel
    input  logic                        sample_valid,
    output logic                        sample_stall,
    input  logic [1:0]                  command,
    input  logic signed [SAMPLE_W-1:0]  mag_x,
    input  logic signed [SAMPLE_W-1:0]  mag_y,
    // result channel
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [HEADING_W-1:0]        heading,
    output logic                        heading_valid,
    output logic                        calibrated,
    output logic signed [SAMPLE_W-1:0]  center_x,
    output logic signed [SAMPLE_W-1:0]  center_y
);

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 16'd50;

    seq_state_t state_reg, state_next;

    logic [SAMPLE_W-1:0]        threshold_reg, threshold_next;
    logic [1:0]                 cmd_reg, cmd_next;
    logic signed [SAMPLE_W-1:0] mag_x_reg, mag_x_next;
    logic signed [SAMPLE_W-1:0] mag_y_reg, mag_y_next;
    logic signed [DELTA_W-1:0]  dx_reg, dx_next;
    logic signed [DELTA_W-1:0]  dy_reg, dy_next;
    logic                       heading_ok_reg, heading_ok_next;
    logic [HEADING_W-1:0]       last_heading_reg, last_heading_next;

    // result register
    logic                       result_valid_reg, result_valid_next;
    logic [HEADING_W-1:0]       heading_reg, heading_next;
    logic                       heading_valid_reg, heading_valid_next;
    logic                       calibrated_reg, calibrated_next;
    logic signed [SAMPLE_W-1:0] center_x_reg, center_x_next;
    logic signed [SAMPLE_W-1:0] center_y_reg, center_y_next;

    logic                       accept;
    logic                       out_free;
    logic                       load_result;
    logic                       cordic_start;
    minmax_ctl_t                mm_ctl;
    cordic_stat_t               cordic_stat;
    logic [HEADING_W-1:0]       cordic_angle;
    logic signed [SAMPLE_W-1:0] mm_center_x, mm_center_y;
    logic                       mm_calibrated;

    assign accept       = sample_valid && !sample_stall;
    assign sample_stall = (state_reg != S_IDLE);
    assign out_free     = !result_valid_reg || !result_stall;

    assign mm_ctl.load = accept;
    assign mm_ctl.eval = (state_reg == S_CENTER);

    cmph_minmax u_minmax (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (mm_ctl),
        .command    (command),
        .mag_x      (mag_x),
        .mag_y      (mag_y),
        .threshold  (threshold_reg),
        .center_x   (mm_center_x),
        .center_y   (mm_center_y),
        .calibrated (mm_calibrated)
    );

    cmph_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .dx    (dx_reg),
        .dy    (dy_reg),
        .stat  (cordic_stat),
        .angle (cordic_angle)
    );

    // Sequencer: accept -> centers -> deltas -> launch -> CORDIC (nonzero heading only) -> result
    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        mag_x_next        = mag_x_reg;
        mag_y_next        = mag_y_reg;
        dx_next           = dx_reg;
        dy_next           = dy_reg;
        heading_ok_next   = heading_ok_reg;
        last_heading_next = last_heading_reg;
        cordic_start      = 1'b0;
        load_result       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next        = command;
                    mag_x_next      = mag_x;
                    mag_y_next      = mag_y;
                    heading_ok_next = 1'b0;
                    state_next      = S_CENTER;
                end
            end
            S_CENTER:
            begin
                // minmax refreshes centers and calibrated flag here
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                dx_next    = DELTA_W'(mag_x_reg) - DELTA_W'(mm_center_x);
                dy_next    = DELTA_W'(mag_y_reg) - DELTA_W'(mm_center_y);
                state_next = S_LAUNCH;
            end
            S_LAUNCH:
            begin
                // skip the CORDIC for a zero vector or a non-heading command
                if ((cmd_reg == CMD_HEADING) && ((dx_reg != '0) || (dy_reg != '0)))
                begin
                    cordic_start = 1'b1;
                    state_next   = S_CORDIC;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CORDIC:
            begin
                if (cordic_stat.done)
                begin
                    last_heading_next = cordic_angle;
                    heading_ok_next   = 1'b1;
                    state_next        = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold here until the result register is free
                if (out_free)
                begin
                    load_result = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        threshold_next = cfg_we ? cfg_wdata : threshold_reg;

        result_valid_next  = result_valid_reg && result_stall;
        heading_next       = heading_reg;
        heading_valid_next = heading_valid_reg;
        calibrated_next    = calibrated_reg;
        center_x_next      = center_x_reg;
        center_y_next      = center_y_reg;
        if (load_result)
        begin
            result_valid_next  = 1'b1;
            heading_next       = last_heading_reg;
            heading_valid_next = heading_ok_reg;
            calibrated_next    = mm_calibrated;
            center_x_next      = mm_center_x;
            center_y_next      = mm_center_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            threshold_reg    <= THRESHOLD_RST;
            heading_ok_reg   <= 1'b0;
            last_heading_reg <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            threshold_reg    <= threshold_next;
            heading_ok_reg   <= heading_ok_next;
            last_heading_reg <= last_heading_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg           <= cmd_next;
        mag_x_reg         <= mag_x_next;
        mag_y_reg         <= mag_y_next;
        dx_reg            <= dx_next;
        dy_reg            <= dy_next;
        heading_reg       <= heading_next;
        heading_valid_reg <= heading_valid_next;
        calibrated_reg    <= calibrated_next;
        center_x_reg      <= center_x_next;
        center_y_reg      <= center_y_next;
    end

    assign result_valid  = result_valid_reg;
    assign heading       = heading_reg;
    assign heading_valid = heading_valid_reg;
    assign calibrated    = calibrated_reg;
    assign center_x      = center_x_reg;
    assign center_y      = center_y_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_to_center: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_CENTER))
        else $error("accepted item did not advance to center stage");

    a_cordic_owned: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_stat.busy |-> (state_reg == S_CORDIC))
        else $error("CORDIC busy outside its sequencer state");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && heading_valid) |-> (heading < HEADING_FULL))
        else $error("heading out of range");

    a_valid_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && heading_ok_reg) |-> (cmd_reg == CMD_HEADING))
        else $error("fresh heading for a non-heading command");

endmodule
